// ----- hdl/ucbs_pkg.sv -----
// ----------------------------------------------------------------------------
// ucbs_pkg
// Shared constants and codes for the uniform cubic B-spline evaluator.
// ----------------------------------------------------------------------------
package ucbs_pkg;

  // Data and accumulator widths
  localparam int DATA_W    = 32;
  localparam int ACC_W     = 40;
  localparam int CIDX_W    = 9;
  localparam int CNT_REG_W = 9;
  localparam int CFG_IDX_W = 2;

  // Command queue between front and back
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = 2;

  // Command codes
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_EVAL  = 1'b1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOWER = 2'd0,
    CFG_UPPER = 2'd1,
    CFG_COUNT = 2'd2,
    CFG_SCALE = 2'd3
  } cfg_reg_t;

  // Divide by three for values below 2^19: (x * MUL) >> SHIFT
  localparam logic [18:0] DIV3_MUL   = 19'd349526;
  localparam int          DIV3_SHIFT = 20;

  // Saturation limits on |s| + 3 for the rounded divide by six
  localparam logic [ACC_W:0] SAT_POS_LIM = 41'd12884901888;
  localparam logic [ACC_W:0] SAT_NEG_LIM = 41'd12884901894;

  localparam logic [DATA_W-1:0] SAT_MAX = 32'h7fff_ffff;
  localparam logic [DATA_W-1:0] SAT_MIN = 32'h8000_0000;

endpackage

// ----- hdl/ucbs_if.sv -----
// ----------------------------------------------------------------------------
// ucbs_req_if / ucbs_rsp_if
// Valid/ready channels carrying the request and response words.
// ----------------------------------------------------------------------------
interface ucbs_req_if;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic signed [31:0] x_value;
  logic        [8:0]  coef_index;
  logic signed [31:0] coef_value;

  modport source (output valid, cmd, x_value, coef_index, coef_value, input ready);
  modport sink   (input valid, cmd, x_value, coef_index, coef_value, output ready);
endinterface

interface ucbs_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] spline_value;
  logic signed [31:0] spline_slope;
  logic               in_range;

  modport source (output valid, spline_value, spline_slope, in_range, input ready);
  modport sink   (input valid, spline_value, spline_slope, in_range, output ready);
endinterface

// ----- hdl/uniform_cubic_bspline_evaluator_unit.sv -----
// ----------------------------------------------------------------------------
// uniform_cubic_bspline_evaluator_unit
// Uniform cubic B-spline evaluator: coefficient writes and point evaluations
// with value and slope outputs, Q16.16 by default.
// ----------------------------------------------------------------------------
//  channel | dir | handshake     | word
//  req     | in  | valid / ready | cmd, x_value, coef_index, coef_value
//  rsp     | out | valid / ready | spline_value, spline_slope, in_range
//  cfg     | in  | cfg_we        | cfg_index, cfg_data
//
//  One word per cycle is accepted while req.ready is high; each request gives
//  one response (3 front stages, queue, 12 back stages).
//  After reset the store is swept to zero, (MAX_INTERVALS+6)/4 rows (65 by
//  default), one row of all four banks per cycle; req.ready is low.
//  A stalled rsp freezes the back pipeline; the four-entry queue absorbs
//  words in flight while the front end keeps accepting until the queue fills.
// ----------------------------------------------------------------------------
module uniform_cubic_bspline_evaluator_unit #(
  parameter int MAX_INTERVALS = 256,
  parameter int FRAC_BITS     = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  ucbs_req_if.sink                       req,
  ucbs_rsp_if.source                     rsp,
  input  logic                           cfg_we,
  input  logic [ucbs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ucbs_pkg::DATA_W-1:0]    cfg_data
);

  localparam int IX_W = ($clog2(MAX_INTERVALS) > 2) ? $clog2(MAX_INTERVALS) : 2;
  localparam int EW   = 2 + IX_W + FRAC_BITS + 1 + ucbs_pkg::CIDX_W + ucbs_pkg::DATA_W;

  logic          busy;
  logic          push_valid, push_ready;
  logic [EW-1:0] push_data;
  logic          pop_valid, pop_ready;
  logic [EW-1:0] pop_data;

  ucbs_front #(
    .MAX_INTERVALS(MAX_INTERVALS), .FRAC_BITS(FRAC_BITS), .EW(EW)
  ) u_front (
    .clk(clk), .rst(rst), .req(req),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .busy(busy),
    .push_valid(push_valid), .push_ready(push_ready), .push_data(push_data)
  );

  ucbs_fifo #(.W(EW)) u_fifo (
    .clk(clk), .rst(rst),
    .push_valid(push_valid), .push_ready(push_ready), .push_data(push_data),
    .pop_valid(pop_valid), .pop_ready(pop_ready), .pop_data(pop_data)
  );

  ucbs_back #(
    .MAX_INTERVALS(MAX_INTERVALS), .FRAC_BITS(FRAC_BITS), .EW(EW)
  ) u_back (
    .clk(clk), .rst(rst),
    .pop_valid(pop_valid), .pop_ready(pop_ready), .pop_data(pop_data),
    .busy(busy), .rsp(rsp)
  );

endmodule

// ----- hdl/ucbs_fifo.sv -----
// ----------------------------------------------------------------------------
// ucbs_fifo
// Short register queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module ucbs_fifo #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push_valid,
  output logic         push_ready,
  input  logic [W-1:0] push_data,
  output logic         pop_valid,
  input  logic         pop_ready,
  output logic [W-1:0] pop_data
);

  logic [W-1:0]                    mem [ucbs_pkg::FIFO_DEPTH];
  logic [ucbs_pkg::FIFO_PTR_W-1:0] wr_ptr;
  logic [ucbs_pkg::FIFO_PTR_W-1:0] rd_ptr;
  logic [ucbs_pkg::FIFO_PTR_W:0]   cnt;
  logic                            do_push;
  logic                            do_pop;

  assign push_ready = (cnt != (ucbs_pkg::FIFO_PTR_W+1)'(ucbs_pkg::FIFO_DEPTH));
  assign pop_valid  = (cnt != '0);
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop)      cnt <= cnt + 1'b1;
      else if (!do_push && do_pop) cnt <= cnt - 1'b1;
    end
  end

  // Store pushed word
  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_data;
  end

endmodule

// ----- hdl/ucbs_front.sv -----
// ----------------------------------------------------------------------------
// ucbs_front
// Accepts request words, holds configuration, range-checks the point, forms
// the local coordinate and classifies it into interval index and fraction.
// ----------------------------------------------------------------------------
module ucbs_front #(
  parameter int MAX_INTERVALS = 256,
  parameter int FRAC_BITS     = 16,
  parameter int EW            = 66
) (
  input  logic                                  clk,
  input  logic                                  rst,
  ucbs_req_if.sink                              req,
  input  logic                                  cfg_we,
  input  logic [ucbs_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [ucbs_pkg::DATA_W-1:0]           cfg_data,
  input  logic                                  busy,
  output logic                                  push_valid,
  input  logic                                  push_ready,
  output logic [EW-1:0]                         push_data
);

  localparam int IX_W  = ($clog2(MAX_INTERVALS) > 2) ? $clog2(MAX_INTERVALS) : 2;
  localparam int CW    = IX_W + 1;
  localparam int FW    = FRAC_BITS + 1;
  localparam int IXR_W = 64 - 2 * FRAC_BITS;

  // Configuration registers
  logic signed [31:0]                   lower_bound;
  logic signed [31:0]                   upper_bound;
  logic [ucbs_pkg::CNT_REG_W-1:0]       interval_count;
  logic [31:0]                          interval_scale;

  // Stage registers
  logic                                 v1, v2, v3;
  logic                                 cmd1, cmd2, cmd3;
  logic                                 ok1, ok2, ok3;
  logic                                 up1, up2;
  logic [31:0]                          diff1;
  logic [63:0]                          prod2;
  logic [ucbs_pkg::CIDX_W-1:0]          cidx1, cidx2, cidx3;
  logic [31:0]                          cval1, cval2, cval3;
  logic [IX_W-1:0]                      ix3;
  logic [FW-1:0]                        f3;

  logic                                 fen;
  logic                                 accept;
  logic                                 in_rng;
  logic signed [32:0]                   diff_w;
  logic [CW-1:0]                        cnt_c;
  logic [IXR_W-1:0]                     ixraw;
  logic                                 past_end;
  logic [IX_W-1:0]                      ix_next;
  logic [FW-1:0]                        f_next;

  assign fen        = !v3 || push_ready;
  assign req.ready  = fen && !busy;
  assign accept     = req.valid && req.ready;
  assign push_valid = v3;
  assign push_data  = {cmd3, ok3, ix3, f3, cidx3, cval3};

  // Write configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      lower_bound    <= '0;
      upper_bound    <= '0;
      interval_count <= ucbs_pkg::CNT_REG_W'(1);
      interval_scale <= '0;
    end else if (cfg_we) begin
      case (ucbs_pkg::cfg_reg_t'(cfg_index))
        ucbs_pkg::CFG_LOWER: lower_bound    <= cfg_data;
        ucbs_pkg::CFG_UPPER: upper_bound    <= cfg_data;
        ucbs_pkg::CFG_COUNT: interval_count <= cfg_data[ucbs_pkg::CNT_REG_W-1:0];
        ucbs_pkg::CFG_SCALE: interval_scale <= cfg_data;
        default: ;
      endcase
    end
  end

  // Range check and offset from the left end
  assign in_rng = (req.x_value >= lower_bound) && (req.x_value <= upper_bound);
  assign diff_w = 33'(req.x_value) - 33'(lower_bound);

  // Clamp the interval count into 1..MAX_INTERVALS
  always_comb begin
    if (interval_count == '0)
      cnt_c = CW'(1);
    else if (32'(interval_count) > 32'(MAX_INTERVALS))
      cnt_c = CW'(MAX_INTERVALS);
    else
      cnt_c = CW'(interval_count);
  end

  // Split the local coordinate into interval and fraction
  always_comb begin
    ixraw    = prod2[63 -: IXR_W];
    past_end = up2 || (ixraw >= IXR_W'(cnt_c));
    if (past_end) begin
      ix_next = IX_W'(cnt_c - CW'(1));
      f_next  = FW'(1) << FRAC_BITS;
    end else begin
      ix_next = ixraw[IX_W-1:0];
      f_next  = {1'b0, prod2[2*FRAC_BITS-1:FRAC_BITS]};
    end
  end

  // Valid bits advance together
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (fen) begin
      v1 <= accept;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // Payload stages
  always_ff @(posedge clk) begin
    if (fen) begin
      cmd1  <= req.cmd;
      ok1   <= (req.cmd == ucbs_pkg::CMD_EVAL) && in_rng;
      up1   <= (req.x_value == upper_bound);
      diff1 <= diff_w[31:0];
      cidx1 <= req.coef_index;
      cval1 <= req.coef_value;

      cmd2  <= cmd1;
      ok2   <= ok1;
      up2   <= up1;
      prod2 <= diff1 * interval_scale;
      cidx2 <= cidx1;
      cval2 <= cval1;

      cmd3  <= cmd2;
      ok3   <= ok2;
      ix3   <= ix_next;
      f3    <= f_next;
      cidx3 <= cidx2;
      cval3 <= cval2;
    end
  end

endmodule

// ----- hdl/ucbs_div6.sv -----
// ----------------------------------------------------------------------------
// ucbs_div6
// Three-stage signed divide by six, rounded half away from zero, saturated
// to 32 bits. Works as a halving then divides by three of a 17-bit high digit and a 16-bit low digit.
// ----------------------------------------------------------------------------
module ucbs_div6 (
  input  logic                               clk,
  input  logic                               en,
  input  logic signed [ucbs_pkg::ACC_W-1:0]  num,
  output logic [ucbs_pkg::DATA_W-1:0]        quo
);

  localparam int AW = ucbs_pkg::ACC_W;

  logic [AW:0]   mag;
  logic [AW:0]   a;
  logic          neg0, sat0;

  logic          neg1, sat1;
  logic [32:0]   b1;

  logic          neg2, sat2;
  logic [16:0]   bh2;
  logic [15:0]   bl2;
  logic [15:0]   qh2;
  logic [37:0]   mh;

  logic          neg3, sat3;
  logic [15:0]   qh3;
  logic [15:0]   ql3;
  logic [17:0]   three_q;
  logic [1:0]    rh;
  logic [17:0]   low;
  logic [37:0]   ml;
  logic [31:0]   q;

  // Magnitude plus half the divisor, saturation test
  always_comb begin
    neg0 = num[AW-1];
    mag  = neg0 ? ({1'b0, ~num} + 1'b1) : {1'b0, num};
    a    = mag + (AW+1)'(3);
    sat0 = neg0 ? (a >= ucbs_pkg::SAT_NEG_LIM) : (a >= ucbs_pkg::SAT_POS_LIM);
  end

  // High digit divide by three
  assign mh = {2'b0, b1[32:16]} * {19'b0, ucbs_pkg::DIV3_MUL};

  // Low digit with remainder of the high digit
  always_comb begin
    three_q = {1'b0, qh2, 1'b0} + {2'b0, qh2};
    rh      = 2'(18'(bh2) - three_q);
    low     = {rh, bl2};
    ml      = {1'b0, low} * {19'b0, ucbs_pkg::DIV3_MUL};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg1 <= neg0;
      sat1 <= sat0;
      b1   <= 33'(a >> 1);

      neg2 <= neg1;
      sat2 <= sat1;
      bh2  <= b1[32:16];
      bl2  <= b1[15:0];
      qh2  <= 16'(mh >> ucbs_pkg::DIV3_SHIFT);

      neg3 <= neg2;
      sat3 <= sat2;
      qh3  <= qh2;
      ql3  <= 16'(ml >> ucbs_pkg::DIV3_SHIFT);
    end
  end

  // Apply sign and saturate
  always_comb begin
    q = {qh3, ql3};
    if (sat3)
      quo = neg3 ? ucbs_pkg::SAT_MIN : ucbs_pkg::SAT_MAX;
    else
      quo = neg3 ? (32'd0 - q) : q;
  end

endmodule

// ----- hdl/ucbs_back.sv -----
// ----------------------------------------------------------------------------
// ucbs_back
// Coefficient store in four interleaved banks, polynomial setup, Horner
// pipeline and rounded divide by six. Clears the store after reset.
// ----------------------------------------------------------------------------
module ucbs_back #(
  parameter int MAX_INTERVALS = 256,
  parameter int FRAC_BITS     = 16,
  parameter int EW            = 66
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          pop_valid,
  output logic          pop_ready,
  input  logic [EW-1:0] pop_data,
  output logic          busy,
  ucbs_rsp_if.source    rsp
);

  localparam int IX_W        = ($clog2(MAX_INTERVALS) > 2) ? $clog2(MAX_INTERVALS) : 2;
  localparam int FW          = FRAC_BITS + 1;
  localparam int STORE_DEPTH = MAX_INTERVALS + 3;
  localparam int BANK_DEPTH  = (MAX_INTERVALS + 6) / 4;
  localparam int ROW_W       = ($clog2(BANK_DEPTH) > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam int AW          = ucbs_pkg::ACC_W;
  localparam int NST         = 11;

  typedef logic signed [AW-1:0] acc_t;

  // Queue head fields
  logic                          h_cmd;
  logic                          h_ok;
  logic [IX_W-1:0]               h_ix;
  logic [FW-1:0]                 h_f;
  logic [ucbs_pkg::CIDX_W-1:0]   h_cidx;
  logic [31:0]                   h_cval;

  logic                          adv;
  logic                          pop;
  logic                          clearing;
  logic [ROW_W-1:0]              clr_row;
  logic [ROW_W-1:0]              base_row;
  logic [ROW_W-1:0]              wr_row;
  logic                          wr_hit;
  wire  [31:0]                   rdw [4];

  logic [NST:1]                  vld;
  logic [NST:1]                  okp;

  // Stage payload
  logic [1:0]                    ixlo1;
  logic [FW-1:0]                 f1, f2, f3, f4, f5, f6;
  acc_t                          e0, e1, e2, e3, t1, t2, p3c;
  acc_t                          p0_2, p1_2, p2_2, p3_2, p3x3_2;
  acc_t                          p0_3, p1_3, p2_3, m3_3, m3d_3;
  acc_t                          p0_4, p1_4, s4, d4;
  acc_t                          p0_5, p1_5, ms5, md5;
  acc_t                          p0_6, s6, d6;
  acc_t                          p0_7, ms7, d7;
  acc_t                          s8, d8;
  logic [31:0]                   quo_v, quo_d;

  function automatic acc_t mulf(acc_t a, logic [FW-1:0] f);
    logic signed [AW+FW:0] full;
    full = a * $signed({1'b0, f});
    return AW'(full >>> FRAC_BITS);
  endfunction

  assign {h_cmd, h_ok, h_ix, h_f, h_cidx, h_cval} = pop_data;

  assign adv       = !rsp.valid || rsp.ready;
  assign pop       = adv && !clearing && pop_valid;
  assign pop_ready = pop;
  assign busy      = clearing;

  // Store addresses: entry e lives in bank e[1:0], row e>>2
  assign base_row = ROW_W'(h_ix >> 2);
  assign wr_row   = ROW_W'(h_cidx >> 2);
  assign wr_hit   = pop && (h_cmd == ucbs_pkg::CMD_WRITE)
                    && (32'(h_cidx) < 32'(STORE_DEPTH));

  // Sweep the store to zero after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_row  <= '0;
    end else if (clearing) begin
      clr_row <= clr_row + 1'b1;
      if (clr_row == ROW_W'(BANK_DEPTH - 1)) clearing <= 1'b0;
    end
  end

  // Four banks, one read each for the four neighbors
  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [31:0]      mem [BANK_DEPTH];
    logic [31:0]      rd_q;
    logic             we;
    logic [ROW_W-1:0] wrow;
    logic [31:0]      wdat;
    logic [ROW_W-1:0] rrow;

    always_comb begin
      we   = clearing || (wr_hit && (h_cidx[1:0] == 2'(b)));
      wrow = clearing ? clr_row : wr_row;
      wdat = clearing ? 32'd0 : h_cval;
      rrow = base_row + ROW_W'(2'(b) < h_ix[1:0]);
    end

    always_ff @(posedge clk) begin
      if (we) mem[wrow] <= wdat;
      if (adv) rd_q <= mem[rrow];
    end

    assign rdw[b] = rd_q;
  end

  // Rotate bank outputs into c0..c3 and form the polynomial
  always_comb begin
    e0  = AW'($signed(rdw[ixlo1]));
    e1  = AW'($signed(rdw[2'(ixlo1 + 2'd1)]));
    e2  = AW'($signed(rdw[2'(ixlo1 + 2'd2)]));
    e3  = AW'($signed(rdw[2'(ixlo1 + 2'd3)]));
    t1  = e0 - (e1 <<< 1) + e2;
    t2  = e1 - e2;
    p3c = e3 - e0 + t2 + (t2 <<< 1);
  end

  // Valid and in-range bits advance with the pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      rsp.valid <= 1'b0;
    end else if (adv) begin
      vld       <= {vld[NST-1:1], pop};
      rsp.valid <= vld[NST];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      okp <= {okp[NST-1:1], h_ok};

      ixlo1 <= h_ix[1:0];
      f1    <= h_f;

      p0_2   <= e0 + (e1 <<< 2) + e2;
      p1_2   <= (e2 - e0) + ((e2 - e0) <<< 1);
      p2_2   <= t1 + (t1 <<< 1);
      p3_2   <= p3c;
      p3x3_2 <= p3c + (p3c <<< 1);
      f2     <= f1;

      p0_3  <= p0_2;
      p1_3  <= p1_2;
      p2_3  <= p2_2;
      m3_3  <= mulf(p3_2, f2);
      m3d_3 <= mulf(p3x3_2, f2);
      f3    <= f2;

      p0_4 <= p0_3;
      p1_4 <= p1_3;
      s4   <= p2_3 + m3_3;
      d4   <= (p2_3 <<< 1) + m3d_3;
      f4   <= f3;

      p0_5 <= p0_4;
      p1_5 <= p1_4;
      ms5  <= mulf(s4, f4);
      md5  <= mulf(d4, f4);
      f5   <= f4;

      p0_6 <= p0_5;
      s6   <= p1_5 + ms5;
      d6   <= p1_5 + md5;
      f6   <= f5;

      p0_7 <= p0_6;
      ms7  <= mulf(s6, f6);
      d7   <= d6;

      s8 <= p0_7 + ms7;
      d8 <= d7;

      rsp.spline_value <= okp[NST] ? quo_v : 32'd0;
      rsp.spline_slope <= okp[NST] ? quo_d : 32'd0;
      rsp.in_range     <= okp[NST];
    end
  end

  ucbs_div6 u_div_value (.clk(clk), .en(adv), .num(s8), .quo(quo_v));
  ucbs_div6 u_div_slope (.clk(clk), .en(adv), .num(d8), .quo(quo_d));

endmodule

// ----- hdl/ucbs_checker.sv -----
// ----------------------------------------------------------------------------
// ucbs_checker
// Port-level checks on the evaluator, attached to the top level by bind.
// ----------------------------------------------------------------------------
module ucbs_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [31:0] rsp_value,
  input logic [31:0] rsp_slope,
  input logic        rsp_in_range
);

  // Hold a stalled response word
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value)
      && $stable(rsp_slope) && $stable(rsp_in_range))
    else $error("response word changed under stall");

  // Out-of-range points and writes give zeros
  a_zero_out: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_in_range |-> rsp_value == 32'd0 && rsp_slope == 32'd0)
    else $error("nonzero result without in_range");

  // Store sweep blocks requests right after reset
  a_clear_block: assert property (@(posedge clk)
    rst |=> !req_ready)
    else $error("request accepted during store sweep");

  // Drop responses at reset
  a_rsp_reset: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid right after reset");

endmodule

bind uniform_cubic_bspline_evaluator_unit ucbs_checker u_chk (
  .clk(clk),
  .rst(rst),
  .req_ready(req.ready),
  .rsp_valid(rsp.valid),
  .rsp_ready(rsp.ready),
  .rsp_value(rsp.spline_value),
  .rsp_slope(rsp.spline_slope),
  .rsp_in_range(rsp.in_range)
);
